>>> rtl/gme_pkg.sv
// Shared types and constants for the gradient magnitude edge detector.
// Used by the channel interfaces and by every module of the block but gme_line_mem.
package gme_pkg;

  localparam int PIX_W         = 8;
  localparam int ROW_W         = 16;
  localparam int COL_W         = 10;
  localparam int IMG_W_W       = 11;
  localparam int IMG_H_W       = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int EDGE_MAX      = 255;
  localparam int RESET_WIDTH   = 512;
  localparam int RESET_HEIGHT  = 512;

  // Sum of two squared 9-bit differences fits in 17 bits; its root in 9.
  localparam int SQ_W   = 17;
  localparam int ROOT_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_SQRT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] radicand;
  } sq_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sq_rsp_t;

endpackage

>>> rtl/gme_pix_if.sv
// Pixel input channel: valid/ready handshake with one grey value per beat.
// Depends on gme_pkg for the pixel width.
interface gme_pix_if;
  logic                       valid;
  logic                       ready;
  logic [gme_pkg::PIX_W-1:0]  pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

>>> rtl/gme_res_if.sv
// Result output channel: edge value with its row and column per beat.
// Depends on gme_pkg for the field widths.
interface gme_res_if;
  logic                       valid;
  logic                       ready;
  logic [gme_pkg::PIX_W-1:0]  edge_value;
  logic [gme_pkg::ROW_W-1:0]  out_row;
  logic [gme_pkg::COL_W-1:0]  out_col;
  logic                       last_of_run;

  modport source (output valid, output edge_value, output out_row, output out_col,
                  output last_of_run, input ready);
  modport sink   (input valid, input edge_value, input out_row, input out_col,
                  input last_of_run, output ready);
endinterface

>>> rtl/gme_cfg_if.sv
// Configuration write channel: register index and write data per beat.
// Depends on gme_pkg for the index and data widths.
interface gme_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gme_pkg::CFG_IDX_W-1:0]   index;
  logic [gme_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/gme_line_mem.sv
// Line store: simple dual-port synchronous RAM, one write and one read port,
// read data registered. No package dependency.
module gme_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/gme_isqrt.sv
// Iterative integer square root, one result bit per cycle (restoring method).
// Depends on gme_pkg for the request/response structs and widths.
module gme_isqrt (
  input  logic             clk,
  input  logic             rst,
  input  gme_pkg::sq_req_t req,
  output gme_pkg::sq_rsp_t rsp
);

  localparam int RW    = gme_pkg::ROOT_W;
  localparam int NW    = 2 * RW;
  localparam int CNT_W = $clog2(RW + 1);

  logic [NW-1:0]    nsh;
  logic [RW+1:0]    rem;
  logic [RW-1:0]    root;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [RW+3:0]    cur;
  logic [RW+3:0]    trial;
  logic [RW+3:0]    diff;
  logic             ge;

  // Bring down the next two radicand bits and try the next root bit.
  always_comb begin
    cur   = {rem, nsh[NW-1 -: 2]};
    trial = (RW + 4)'({root, 2'b01});
    ge    = cur >= trial;
    diff  = cur - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(RW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      nsh  <= NW'(req.radicand);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      nsh  <= nsh << 2;
      rem  <= ge ? diff[RW+1:0] : cur[RW+1:0];
      root <= {root[RW-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

>>> rtl/gradient_magnitude_edge.sv
// Forward-difference gradient magnitude edge detector. Pixels enter in raster
// order, one per beat; results come out one row late (in the last row, with that
// row's own pixels) as up to three beats per pixel, the final beat of each pixel
// flagged by last_of_run. The block works on one pixel at a time: it accepts the
// pixel, makes two reads of the single read port of the line store, runs the
// 9-step square root unit for a pixel in a later row, then sends each result
// beat and waits out any stall on the result side. The line store needs
// no clearing after reset. Depends on gme_pkg, the channel interfaces,
// gme_line_mem and gme_isqrt.
module gradient_magnitude_edge #(
  parameter int MAX_WIDTH = gme_pkg::MAX_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  gme_pix_if.sink    pixels,
  gme_res_if.source  results,
  gme_cfg_if.sink    cfg
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = (CW + 1 > gme_pkg::IMG_W_W) ? CW + 1 : gme_pkg::IMG_W_W;
  localparam int PW = gme_pkg::PIX_W;
  localparam int RW = gme_pkg::ROW_W;

  gme_pkg::state_t state, state_next;

  logic [gme_pkg::IMG_W_W-1:0] width_reg;
  logic [gme_pkg::IMG_H_W-1:0] height_reg;
  logic [RW-1:0]               row_cnt;
  logic [CW-1:0]               col_cnt;
  logic [PW-1:0]               prev_pix;

  logic [PW-1:0] cur_pix;
  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic          cur_last_col;
  logic [PW-1:0] cur_diff;
  logic [PW-1:0] above;
  logic [PW-1:0] mag;
  logic [2:0]    pend;
  logic [2:0]    pend_next;
  logic [2:0]    pick;

  logic          out_valid;
  logic [PW-1:0] out_val;
  logic [RW-1:0] out_row;
  logic [CW-1:0] out_col;
  logic          out_last;

  logic [LW-1:0] w_ext;
  logic [LW-1:0] w_eff;
  logic [gme_pkg::IMG_H_W-1:0] h_eff;
  logic          last_col_now;
  logic          last_row_now;
  logic [PW-1:0] diff_now;
  logic          accept;

  logic          mem_rd_en;
  logic [CW-1:0] mem_rd_addr;
  logic [PW-1:0] mem_rd_data;
  logic          mem_wr_en;

  logic signed [PW:0]     gx;
  logic signed [PW:0]     gy;
  logic signed [2*PW+1:0] sqx;
  logic signed [2*PW+1:0] sqy;

  gme_pkg::sq_req_t sq_req;
  gme_pkg::sq_rsp_t sq_rsp;

  logic out_load;
  logic out_free;

  gme_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (PW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (cur_col),
    .wr_data (cur_pix)
  );

  gme_isqrt u_isqrt (
    .clk (clk),
    .rst (rst),
    .req (sq_req),
    .rsp (sq_rsp)
  );

  // Effective frame geometry; zero sizes act as one, widths above the store clamp.
  always_comb begin
    w_ext = LW'(width_reg);
    if (w_ext == '0) begin
      w_eff = LW'(1);
    end else if (w_ext > LW'(MAX_WIDTH)) begin
      w_eff = LW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_eff        = (height_reg == '0) ? gme_pkg::IMG_H_W'(1) : height_reg;
    last_col_now = LW'(col_cnt) >= (w_eff - LW'(1));
    last_row_now = row_cnt >= (h_eff - gme_pkg::IMG_H_W'(1));
    diff_now     = (pixels.pixel >= prev_pix) ? (pixels.pixel - prev_pix)
                                              : (prev_pix - pixels.pixel);
  end

  // Gradients: the line store holds the row above; the second read brings its
  // right-hand neighbor.
  always_comb begin
    gx  = cur_last_col ? '0 : ($signed({1'b0, mem_rd_data}) - $signed({1'b0, above}));
    gy  = $signed({1'b0, cur_pix}) - $signed({1'b0, above});
    sqx = gx * gx;
    sqy = gy * gy;
    sq_req.start    = (state == gme_pkg::ST_RD_B) && pend[0];
    sq_req.radicand = gme_pkg::SQ_W'(sqx) + gme_pkg::SQ_W'(sqy);
  end

  assign out_free = !out_valid || results.ready;

  always_comb begin
    if (pend[0]) begin
      pick = 3'b001;
    end else if (pend[1]) begin
      pick = 3'b010;
    end else begin
      pick = 3'b100;
    end
    pend_next = pend & ~pick;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      gme_pkg::ST_IDLE: begin
        if (pixels.valid) begin
          state_next = gme_pkg::ST_RD_A;
        end
      end
      gme_pkg::ST_RD_A: state_next = gme_pkg::ST_RD_B;
      gme_pkg::ST_RD_B: state_next = pend[0] ? gme_pkg::ST_SQRT : gme_pkg::ST_OUT;
      gme_pkg::ST_SQRT: begin
        if (sq_rsp.done) begin
          state_next = gme_pkg::ST_OUT;
        end
      end
      gme_pkg::ST_OUT: begin
        if (pend == '0 || (out_free && pend_next == '0)) begin
          state_next = gme_pkg::ST_IDLE;
        end
      end
      default: state_next = gme_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pixels.ready = 1'b0;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = col_cnt;
    mem_wr_en    = 1'b0;
    out_load     = 1'b0;
    case (state)
      gme_pkg::ST_IDLE: begin
        pixels.ready = 1'b1;
        mem_rd_en    = 1'b1;
      end
      gme_pkg::ST_RD_A: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = cur_col + CW'(1);
      end
      gme_pkg::ST_RD_B: begin
        mem_wr_en = 1'b1;
      end
      gme_pkg::ST_SQRT: ;
      gme_pkg::ST_OUT: begin
        out_load = out_free && (pend != '0);
      end
      default: ;
    endcase
  end

  assign accept = pixels.valid && pixels.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gme_pkg::ST_IDLE;
      width_reg  <= gme_pkg::IMG_W_W'(gme_pkg::RESET_WIDTH);
      height_reg <= gme_pkg::IMG_H_W'(gme_pkg::RESET_HEIGHT);
      row_cnt    <= '0;
      col_cnt    <= '0;
      prev_pix   <= '0;
      pend       <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (cfg.index)
          gme_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg.data[gme_pkg::IMG_W_W-1:0];
          gme_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg.data[gme_pkg::IMG_H_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        prev_pix <= pixels.pixel;
        pend     <= {last_row_now && last_col_now,
                     last_row_now && (col_cnt != '0),
                     row_cnt != '0};
        if (last_col_now) begin
          col_cnt <= '0;
          row_cnt <= last_row_now ? '0 : row_cnt + RW'(1);
        end else begin
          col_cnt <= col_cnt + CW'(1);
        end
      end else if (out_load) begin
        pend <= pend_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_pix      <= pixels.pixel;
      cur_row      <= row_cnt;
      cur_col      <= col_cnt;
      cur_last_col <= last_col_now;
      cur_diff     <= diff_now;
    end
    if (state == gme_pkg::ST_RD_A) begin
      above <= mem_rd_data;
    end
    if (state == gme_pkg::ST_SQRT && sq_rsp.done) begin
      mag <= (sq_rsp.root > gme_pkg::ROOT_W'(gme_pkg::EDGE_MAX))
             ? PW'(gme_pkg::EDGE_MAX) : sq_rsp.root[PW-1:0];
    end
    if (out_load) begin
      out_last <= (pend_next == '0);
      if (pick[0]) begin
        out_val <= mag;
        out_row <= cur_row - RW'(1);
        out_col <= cur_col;
      end else if (pick[1]) begin
        out_val <= cur_diff;
        out_row <= cur_row;
        out_col <= cur_col - CW'(1);
      end else begin
        out_val <= '0;
        out_row <= cur_row;
        out_col <= cur_col;
      end
    end
  end

  assign results.valid       = out_valid;
  assign results.edge_value  = out_val;
  assign results.out_row     = out_row;
  assign results.out_col     = gme_pkg::COL_W'(out_col);
  assign results.last_of_run = out_last;

endmodule

>>> test/edge_result_checker.sv
// Result checker for the gradient magnitude edge detector: watches the pixel,
// result and register channels, predicts every result beat and compares them.
// Depends on gme_pkg and the three channel interfaces.
module edge_result_checker
  import gme_pkg::*;
(
  input  logic clk,
  input  logic rst,
  gme_pix_if   pix,
  gme_res_if   res,
  gme_cfg_if   cfg,
  output int   failures,
  output int   pending,
  output int   beats_checked
);

  localparam int LINE_DEPTH = MAX_WIDTH_DEF;

  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             last_of_run;
  } edge_beat_t;

  logic [IMG_W_W-1:0] width_reg;
  logic [IMG_H_W-1:0] height_reg;
  logic [PIX_W-1:0]   line_buf [LINE_DEPTH];
  logic [ROW_W-1:0]   row_pos;
  logic [COL_W-1:0]   col_pos;
  logic [PIX_W-1:0]   left_pixel;
  edge_beat_t         pending_edges[$];

  // Floor square root built bit by bit from the top, then clamped to 8 bits.
  function automatic logic [PIX_W-1:0] gradient_magnitude(int gx, int gy);
    int sum;
    int root;
    int trial;
    int b;
    sum  = gx * gx + gy * gy;
    root = 0;
    for (b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= sum) root = trial;
    end
    return (root > EDGE_MAX) ? PIX_W'(EDGE_MAX) : PIX_W'(root);
  endfunction

  task automatic predict_edges(input logic [PIX_W-1:0] p);
    int         w;
    int         h;
    int         r;
    int         c;
    int         above;
    int         gx;
    int         n;
    bit         last_col;
    bit         last_row;
    edge_beat_t beats [3];
    w = width_reg;
    if (w < 1) w = 1;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    h = height_reg;
    if (h < 1) h = 1;
    r = row_pos;
    c = col_pos;
    last_col = (c >= w - 1);
    last_row = (r >= h - 1);
    n = 0;
    // The pixel below completes the result of the row above.
    if (r > 0) begin
      above = line_buf[c];
      gx = last_col ? 0 : int'(line_buf[c + 1]) - above;
      beats[n] = '{gradient_magnitude(gx, int'(p) - above), ROW_W'(r - 1), COL_W'(c), 1'b0};
      n++;
    end
    // In the last row there is nothing below, so the left neighbor is final now.
    if (last_row && c > 0) begin
      beats[n] = '{gradient_magnitude(int'(p) - int'(left_pixel), 0),
                   ROW_W'(r), COL_W'(c - 1), 1'b0};
      n++;
    end
    if (last_row && last_col) begin
      beats[n] = '{'0, ROW_W'(r), COL_W'(c), 1'b0};
      n++;
    end
    if (n > 0) beats[n - 1].last_of_run = 1'b1;
    for (int k = 0; k < n; k++) pending_edges.push_back(beats[k]);

    line_buf[c] = p;
    left_pixel  = p;
    if (last_col) begin
      col_pos = '0;
      row_pos = last_row ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = COL_W'(c + 1);
    end
  endtask

  always @(posedge clk) begin : monitor
    edge_beat_t want;
    if (rst) begin
      width_reg     = IMG_W_W'(RESET_WIDTH);
      height_reg    = IMG_H_W'(RESET_HEIGHT);
      row_pos       = '0;
      col_pos       = '0;
      left_pixel    = '0;
      failures      = 0;
      beats_checked = 0;
      pending_edges.delete();
    end else begin
      // A result beat can never come from the pixel taken at the same edge.
      if (res.valid && res.ready) begin
        beats_checked++;
        if (pending_edges.size() == 0) begin
          $error("unexpected result beat: row %0d col %0d value %0d",
                 res.out_row, res.out_col, res.edge_value);
          failures++;
        end else begin
          want = pending_edges.pop_front();
          if (res.edge_value !== want.edge_value) begin
            $error("edge_value: expected %0d, actual %0d", want.edge_value, res.edge_value);
            failures++;
          end
          if (res.out_row !== want.out_row) begin
            $error("out_row: expected %0d, actual %0d", want.out_row, res.out_row);
            failures++;
          end
          if (res.out_col !== want.out_col) begin
            $error("out_col: expected %0d, actual %0d", want.out_col, res.out_col);
            failures++;
          end
          if (res.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d", want.last_of_run,
                   res.last_of_run);
            failures++;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_IMAGE_WIDTH:  width_reg  = cfg.data[IMG_W_W-1:0];
          REG_IMAGE_HEIGHT: height_reg = cfg.data[IMG_H_W-1:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) predict_edges(pix.pixel);
    end
    pending = pending_edges.size();
  end

endmodule

>>> test/gradient_magnitude_edge_tb.sv
// Top of the edge detector testbench: clock, reset, pixel and register stimulus,
// result back-pressure and the verdict.
// Depends on gme_pkg, the channel interfaces, the block and edge_result_checker.
module gradient_magnitude_edge_tb;
  import gme_pkg::*;

  localparam int TOTAL_ITEMS    = 400;
  localparam int CALM_ITEMS     = 70;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 24;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  // Index outside the register map; the block must take and ignore it.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {PIX_NOISE, PIX_EXTREME, PIX_RAMP} pixel_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm;
  bit   hold_req;
  bit   hold_done;
  int   failures;
  int   pending;
  int   results_seen;
  int   sent;
  int   settings_used;

  gme_pix_if pix_if ();
  gme_res_if res_if ();
  gme_cfg_if cfg_if ();

  gradient_magnitude_edge DUT (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_if),
    .results (res_if),
    .cfg     (cfg_if)
  );

  edge_result_checker result_check (
    .clk           (clk),
    .rst           (rst),
    .pix           (pix_if),
    .res           (res_if),
    .cfg           (cfg_if),
    .failures      (failures),
    .pending       (pending),
    .beats_checked (results_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic push_pixel(input logic [PIX_W-1:0] value);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      pix_if.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    pix_if.valid = 1'b1;
    pix_if.pixel = value;
    do @(posedge clk); while (!pix_if.ready);
    sent++;
  endtask

  task automatic pix_stop();
    @(negedge clk);
    pix_if.valid = 1'b0;
  endtask

  // Wait until every predicted beat is out, then give the block time to finish
  // pixels that release no result.
  task automatic settle();
    pix_stop();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = index;
    cfg_if.data  = data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] width_data,
                           input logic [CFG_DATA_W-1:0] height_data);
    if ($urandom_range(0, 1) != 0) begin
      write_reg(REG_IMAGE_WIDTH, width_data);
      write_reg(REG_IMAGE_HEIGHT, height_data);
    end else begin
      write_reg(REG_IMAGE_HEIGHT, height_data);
      write_reg(REG_IMAGE_WIDTH, width_data);
    end
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    settings_used++;
  endtask

  function automatic logic [PIX_W-1:0] next_pixel(pixel_style_t style,
                                                  logic [PIX_W-1:0] prior);
    case (style)
      PIX_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      PIX_RAMP:    return prior + PIX_W'($urandom_range(0, 8)) - 8'd4;
      default:     return PIX_W'($urandom);
    endcase
  endfunction

  // Result side: random stall bursts, plus one long hold that backs up the block.
  initial begin : result_sink
    int n;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        res_if.ready = 1'b0;
        n = $urandom_range(1, 4);
        repeat (n - 1) @(negedge clk);
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $error("no beat on any channel for %0d cycles", WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int                  w;
    int                  h;
    int                  frames;
    int                  count;
    int                  phase;
    logic [CFG_DATA_W-1:0] wdata;
    logic [CFG_DATA_W-1:0] hdata;
    logic [PIX_W-1:0]    last_px;
    pixel_style_t        style;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero width and height act as one: every pixel is a whole frame.
    write_reg(REG_UNUSED, 16'hFFFF);
    configure(16'd0, 16'd0);
    push_pixel(8'h00);
    push_pixel(8'hFF);
    settle();

    // Full-scale steps in both directions, including the clamped corner case.
    configure(16'd3, 16'd2);
    push_pixel(8'h00); push_pixel(8'hFF); push_pixel(8'h00);
    push_pixel(8'hFF); push_pixel(8'h00); push_pixel(8'hFF);
    settle();

    // Single column.
    configure(16'd1, 16'd2);
    push_pixel(8'hFF); push_pixel(8'h00);
    settle();

    // Single row.
    configure(16'd3, 16'd1);
    push_pixel(8'hFF); push_pixel(8'h00); push_pixel(8'hFF);
    settle();

    // Width above the maximum, then narrowed mid-row so the row ends at once.
    configure(16'd2047, 16'd1);
    push_pixel(8'd17); push_pixel(8'd200); push_pixel(8'hFF);
    settle();
    write_reg(REG_IMAGE_WIDTH, 16'd2);
    push_pixel(8'h00);
    settle();

    // Tallest frame, then height cut to zero mid-frame so this row is the last.
    configure(16'd2, 16'hFFFF);
    push_pixel(8'hFF); push_pixel(8'h00); push_pixel(8'h00); push_pixel(8'hFF);
    settle();
    write_reg(REG_IMAGE_HEIGHT, 16'd0);
    push_pixel(8'hFF); push_pixel(8'h00);
    settle();

    // Random frames; each phase sends whole frames so settings change on a frame
    // boundary and the line store is always filled before it is read.
    phase = 0;
    while (sent < TOTAL_ITEMS) begin
      if (phase == 0) begin
        w = 6;
        h = 4;
        frames = 2;
      end else begin
        w = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        h = (w > 8) ? $urandom_range(1, 2) : $urandom_range(1, 6);
        frames = $urandom_range(1, 2);
      end
      wdata = (w == 1 && $urandom_range(0, 2) == 0) ? '0 : CFG_DATA_W'(w);
      if ($urandom_range(0, 2) == 0) wdata[CFG_DATA_W-1:IMG_W_W] = 5'($urandom);
      hdata = (h == 1 && $urandom_range(0, 2) == 0) ? '0 : CFG_DATA_W'(h);
      style = pixel_style_t'($urandom_range(0, 2));
      calm  = (sent >= TOTAL_ITEMS - CALM_ITEMS);
      configure(wdata, hdata);
      count   = w * h * frames;
      last_px = PIX_W'($urandom);
      for (int k = 0; k < count; k++) begin
        if (phase == 0 && k == 12) hold_req = 1'b1;
        if (phase == 1 && k == count / 2) begin
          pix_stop();
          while (pending != 0) @(negedge clk);
        end
        last_px = next_pixel(style, last_px);
        push_pixel(last_px);
      end
      settle();
      phase++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d pixels under %0d register settings, %0d result beats checked,",
             sent, settings_used, results_seen);
    $display("with one long result stall and one full drain in mid-frame.");
    if (failures == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      if (pending != 0) $error("%0d expected result beats never arrived", pending);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/gme_pkg.sv
rtl/gme_pix_if.sv
rtl/gme_res_if.sv
rtl/gme_cfg_if.sv
rtl/gme_line_mem.sv
rtl/gme_isqrt.sv
rtl/gradient_magnitude_edge.sv
test/edge_result_checker.sv
test/gradient_magnitude_edge_tb.sv
